// ----- rtl/dsc_pkg.sv -----
// Package for the CPU debug step controller.
// Holds mode and operation codes, opcode constants, item types and bank lookup.
// No dependencies.
package dsc_pkg;

  localparam int InDataWidth  = 208;
  localparam int OutDataWidth = 32;

  localparam logic [2:0] OP_CHECK    = 3'd0;
  localparam logic [2:0] OP_CONTINUE = 3'd1;
  localparam logic [2:0] OP_PAUSE    = 3'd2;
  localparam logic [2:0] OP_INTO     = 3'd3;
  localparam logic [2:0] OP_OVER     = 3'd4;
  localparam logic [2:0] OP_OUT      = 3'd5;

  localparam logic [2:0] MODE_RUN        = 3'd0;
  localparam logic [2:0] MODE_PAUSE      = 3'd1;
  localparam logic [2:0] MODE_INTO       = 3'd2;
  localparam logic [2:0] MODE_OVER       = 3'd3;
  localparam logic [2:0] MODE_OUT_RUN    = 3'd4;
  localparam logic [2:0] MODE_OUT_OVER   = 3'd5;
  localparam logic [2:0] MODE_OUT_RETURN = 3'd6;

  localparam logic [7:0] OPC_JSR = 8'h20;
  localparam logic [7:0] OPC_RTS = 8'h60;
  localparam logic [7:0] OPC_RTI = 8'h40;
  localparam logic [7:0] OPC_WAI = 8'hcb;

  localparam logic [15:0] RAM_WINDOW_BASE = 16'ha000;
  localparam logic [15:0] ROM_WINDOW_BASE = 16'hc000;
  localparam logic [15:0] JSR_LENGTH      = 16'd3;
  localparam logic [15:0] WAI_LENGTH      = 16'd1;

  typedef struct packed {
    logic [2:0]  operation;
    logic [15:0] pc;
    logic [7:0]  ram_bank;
    logic [7:0]  rom_bank;
    logic [7:0]  opcode;
    logic        irq_disable;
    logic        cpu_waiting;
    logic [15:0] stack_word_one;
    logic [15:0] stack_word_two;
    logic [63:0] clock_ticks;
    logic [31:0] retired_instructions;
    logic [31:0] step_count;
  } item_t;

  typedef struct packed {
    logic        paused;
    logic [2:0]  next_mode;
    logic [15:0] target_address;
    logic [7:0]  target_bank_out;
  } result_t;

  function automatic logic [7:0] bank_of(input logic [15:0] addr,
                                         input logic [7:0] ram,
                                         input logic [7:0] rom);
    logic [7:0] bank;
    if (addr < RAM_WINDOW_BASE) begin
      bank = 8'd0;
    end else if (addr < ROM_WINDOW_BASE) begin
      bank = ram;
    end else begin
      bank = rom;
    end
    return bank;
  endfunction

endpackage

// ----- rtl/dsc_input_stage.sv -----
// Input register of the debug step controller.
// Unpacks the stream transaction into an item and holds it until the core takes it.
// Depends on dsc_pkg.
module dsc_input_stage import dsc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [InDataWidth-1:0] s_axis_tdata,
  input  logic [2:0]             s_axis_tuser,
  input  logic                   take,
  output logic                   item_valid,
  output item_t                  item
);

  item_t item_next;

  assign s_axis_tready = !item_valid || take;

  always_comb begin
    item_next.operation            = s_axis_tuser;
    item_next.pc                   = s_axis_tdata[15:0];
    item_next.ram_bank             = s_axis_tdata[23:16];
    item_next.rom_bank             = s_axis_tdata[31:24];
    item_next.opcode               = s_axis_tdata[39:32];
    item_next.irq_disable          = s_axis_tdata[40];
    item_next.cpu_waiting          = s_axis_tdata[41];
    item_next.stack_word_one       = s_axis_tdata[57:42];
    item_next.stack_word_two       = s_axis_tdata[73:58];
    item_next.clock_ticks          = s_axis_tdata[137:74];
    item_next.retired_instructions = s_axis_tdata[169:138];
    item_next.step_count           = s_axis_tdata[201:170];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_axis_tready) begin
      item_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item <= item_next;
    end
  end

endmodule

// ----- rtl/dsc_step_core.sv -----
// Step state and decision logic of the debug step controller.
// Holds mode, start counts and target; updates them when an item is taken.
// Depends on dsc_pkg.
module dsc_step_core import dsc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    take,
  input  item_t   item,
  output result_t result
);

  logic [2:0]  mode;
  logic [63:0] start_clock;
  logic [31:0] start_instructions;
  logic        start_irq_flag;
  logic [15:0] target_pc;
  logic [7:0]  target_bank;
  logic [31:0] instruction_goal;

  logic [2:0]  mode_next;
  logic [63:0] start_clock_next;
  logic [31:0] start_instructions_next;
  logic        start_irq_flag_next;
  logic [15:0] target_pc_next;
  logic [7:0]  target_bank_next;
  logic [31:0] instruction_goal_next;
  logic        paused;

  logic [7:0]  cur_bank;
  logic        exited;
  logic        same;
  logic        at_target;
  logic [31:0] retired_delta;
  logic        goal_reached;
  logic        is_jsr;
  logic        is_rts;
  logic        is_rti;
  logic        is_wai;
  logic [15:0] jsr_return;
  logic [15:0] wai_return;
  logic [15:0] stack_return;
  logic [7:0]  stack_bank;

  assign cur_bank      = bank_of(item.pc, item.ram_bank, item.rom_bank);
  assign exited        = start_irq_flag && !item.irq_disable;
  assign same          = item.irq_disable == start_irq_flag;
  assign at_target     = (item.pc == target_pc) && (cur_bank == target_bank);
  assign retired_delta = item.retired_instructions - start_instructions;
  assign goal_reached  = retired_delta >= instruction_goal;
  assign is_jsr        = item.opcode == OPC_JSR;
  assign is_rts        = item.opcode == OPC_RTS;
  assign is_rti        = item.opcode == OPC_RTI;
  assign is_wai        = item.opcode == OPC_WAI;
  assign jsr_return    = item.pc + JSR_LENGTH;
  assign wai_return    = item.pc + WAI_LENGTH;
  assign stack_return  = is_rts ? (item.stack_word_one + 16'd1) : item.stack_word_two;
  assign stack_bank    = bank_of(stack_return, item.ram_bank, item.rom_bank);

  always_comb begin
    mode_next               = mode;
    start_clock_next        = start_clock;
    start_instructions_next = start_instructions;
    start_irq_flag_next     = start_irq_flag;
    target_pc_next          = target_pc;
    target_bank_next        = target_bank;
    instruction_goal_next   = instruction_goal;
    paused                  = 1'b0;

    case (item.operation)
      OP_CHECK: begin
        case (mode)
          MODE_PAUSE: begin
            paused = 1'b1;
          end
          MODE_INTO: begin
            if (instruction_goal != 32'd0) begin
              if (goal_reached) begin
                instruction_goal_next = 32'd0;
                mode_next             = MODE_PAUSE;
                paused                = 1'b1;
              end
            end else if (!item.cpu_waiting && (start_clock != item.clock_ticks)) begin
              mode_next = MODE_PAUSE;
              paused    = 1'b1;
            end
          end
          MODE_OVER: begin
            if (exited || (!item.cpu_waiting && same && at_target)) begin
              mode_next = MODE_PAUSE;
              paused    = 1'b1;
            end
          end
          MODE_OUT_RUN: begin
            if (exited) begin
              mode_next = MODE_PAUSE;
              paused    = 1'b1;
            end else if (same) begin
              if (is_jsr) begin
                mode_next        = MODE_OUT_OVER;
                target_pc_next   = jsr_return;
                target_bank_next = cur_bank;
              end else if (is_rts || is_rti) begin
                mode_next        = MODE_OUT_RETURN;
                target_pc_next   = stack_return;
                target_bank_next = stack_bank;
              end
            end
          end
          MODE_OUT_OVER: begin
            if (exited) begin
              mode_next = MODE_PAUSE;
              paused    = 1'b1;
            end else if (same && at_target) begin
              mode_next = MODE_OUT_RUN;
              paused    = 1'b1;
            end
          end
          MODE_OUT_RETURN: begin
            if (exited || (same && at_target)) begin
              mode_next = MODE_PAUSE;
              paused    = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      OP_CONTINUE: begin
        mode_next               = MODE_RUN;
        start_clock_next        = item.clock_ticks;
        start_instructions_next = item.retired_instructions;
        start_irq_flag_next     = 1'b1;
      end
      OP_PAUSE: begin
        mode_next = MODE_PAUSE;
      end
      OP_INTO: begin
        mode_next               = MODE_INTO;
        start_clock_next        = item.clock_ticks;
        start_instructions_next = item.retired_instructions;
        start_irq_flag_next     = item.irq_disable;
        instruction_goal_next   = item.step_count;
      end
      OP_OVER: begin
        start_clock_next        = item.clock_ticks;
        start_instructions_next = item.retired_instructions;
        start_irq_flag_next     = item.irq_disable;
        if (is_jsr || is_wai) begin
          mode_next        = MODE_OVER;
          target_pc_next   = is_jsr ? jsr_return : wai_return;
          target_bank_next = cur_bank;
        end else begin
          mode_next             = MODE_INTO;
          instruction_goal_next = 32'd0;
        end
      end
      OP_OUT: begin
        start_clock_next    = item.clock_ticks;
        start_irq_flag_next = item.irq_disable;
        if (is_jsr) begin
          mode_next        = MODE_OUT_OVER;
          target_pc_next   = jsr_return;
          target_bank_next = cur_bank;
        end else if (is_rts || is_rti) begin
          mode_next        = MODE_OUT_RETURN;
          target_pc_next   = stack_return;
          target_bank_next = stack_bank;
        end else begin
          mode_next = MODE_OUT_RUN;
        end
      end
      default: begin
      end
    endcase

    if (item.operation != OP_CHECK) begin
      paused = mode_next == MODE_PAUSE;
    end
  end

  assign result.paused          = paused;
  assign result.next_mode       = mode_next;
  assign result.target_address  = target_pc_next;
  assign result.target_bank_out = target_bank_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode               <= MODE_RUN;
      start_clock        <= 64'd0;
      start_instructions <= 32'd0;
      start_irq_flag     <= 1'b1;
      target_pc          <= 16'd0;
      target_bank        <= 8'd0;
      instruction_goal   <= 32'd0;
    end else if (take) begin
      mode               <= mode_next;
      start_clock        <= start_clock_next;
      start_instructions <= start_instructions_next;
      start_irq_flag     <= start_irq_flag_next;
      target_pc          <= target_pc_next;
      target_bank        <= target_bank_next;
      instruction_goal   <= instruction_goal_next;
    end
  end

endmodule

// ----- rtl/cpu_debug_step_controller.sv -----
// Top level of the CPU debug step controller.
// Input register, step core and result register; depends on dsc_pkg,
// dsc_input_stage and dsc_step_core.
//
//   channel  | direction | contents
//   s_axis   | in        | tuser: operation; tdata: boundary snapshot and step count
//   m_axis   | out       | tdata: paused, next mode, target address and bank
//
// One transaction in and one out per cycle while m_axis_tready does not stall it.
// The decision for an item is made in the cycle it leaves the input register.
// Reset clears mode to run and both valid flags; no clearing pass.
// A stalled result holds the input register, which holds s_axis_tready low.
module cpu_debug_step_controller import dsc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // pc[15:0], ram_bank[23:16], rom_bank[31:24], opcode[39:32], irq_disable[40],
  // cpu_waiting[41], stack_word_one[57:42], stack_word_two[73:58],
  // clock_ticks[137:74], retired_instructions[169:138], step_count[201:170]
  input  logic [InDataWidth-1:0]  s_axis_tdata,
  // operation[2:0]
  input  logic [2:0]              s_axis_tuser,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // paused[0], next_mode[3:1], target_address[19:4], target_bank_out[27:20]
  output logic [OutDataWidth-1:0] m_axis_tdata
);

  logic    item_valid;
  item_t   item;
  result_t result;
  result_t held;
  logic    take;

  assign take = item_valid && (!m_axis_tvalid || m_axis_tready);

  dsc_input_stage u_input (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .take          (take),
    .item_valid    (item_valid),
    .item          (item)
  );

  dsc_step_core u_core (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .item   (item),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (take) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held <= result;
    end
  end

  assign m_axis_tdata = {4'd0, held.target_bank_out, held.target_address,
                         held.next_mode, held.paused};

  a_paused_mode: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && held.paused |->
      (held.next_mode == MODE_PAUSE) || (held.next_mode == MODE_OUT_RUN))
    else $error("paused reported outside pause or out-run");

  a_mode_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> held.next_mode != 3'd7)
    else $error("unreachable mode reported");

  a_item_held: assert property (@(posedge clk) disable iff (rst)
    item_valid && !take |=> item_valid && $stable(item))
    else $error("input register lost an item");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(held))
    else $error("result changed under stall");

  a_take_refills: assert property (@(posedge clk) disable iff (rst)
    take |=> m_axis_tvalid)
    else $error("taken item produced no result");

endmodule

// ----- test/cpu_debug_step_controller_tb.sv -----
// Self-checking testbench for the CPU debug step controller.
// A scoreboard class predicts each decision from the accepted transaction;
// depends on dsc_pkg and the cpu_debug_step_controller RTL.
`timescale 1ns / 100ps

import dsc_pkg::*;

class step_scoreboard;
  logic [2:0]  mode;
  logic [63:0] start_clock;
  logic [31:0] start_count;
  logic        start_irq;
  logic [15:0] goal_pc;
  logic [7:0]  goal_bank;
  logic [31:0] count_goal;
  result_t     due_decisions[$];
  int unsigned mismatches;

  function new();
    mode        = MODE_RUN;
    start_clock = '0;
    start_count = '0;
    start_irq   = 1'b1;
    goal_pc     = '0;
    goal_bank   = '0;
    count_goal  = '0;
    mismatches  = 0;
  endfunction

  function logic [7:0] window_bank(logic [15:0] addr, item_t it);
    if (addr >= ROM_WINDOW_BASE) return it.rom_bank;
    if (addr >= RAM_WINDOW_BASE) return it.ram_bank;
    return 8'd0;
  endfunction

  function void arm_into(item_t it, logic [31:0] count);
    mode        = MODE_INTO;
    start_clock = it.clock_ticks;
    start_count = it.retired_instructions;
    start_irq   = it.irq_disable;
    count_goal  = count;
  endfunction

  // aim step-out at a JSR return point or the stacked return address
  function logic aim_out(item_t it);
    case (it.opcode)
      OPC_JSR: begin
        mode      = MODE_OUT_OVER;
        goal_pc   = it.pc + JSR_LENGTH;
        goal_bank = window_bank(it.pc, it);
      end
      OPC_RTS: begin
        mode      = MODE_OUT_RETURN;
        goal_pc   = it.stack_word_one + 16'd1;
        goal_bank = window_bank(goal_pc, it);
      end
      OPC_RTI: begin
        mode      = MODE_OUT_RETURN;
        goal_pc   = it.stack_word_two;
        goal_bank = window_bank(goal_pc, it);
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function void note_item(item_t it);
    logic    exited;
    logic    same;
    logic    at_goal;
    logic    hold;
    result_t r;
    exited  = start_irq && !it.irq_disable;
    same    = (it.irq_disable == start_irq);
    at_goal = (it.pc == goal_pc) && (window_bank(it.pc, it) == goal_bank);
    hold    = 1'b0;
    case (it.operation)
      OP_CHECK: begin
        case (mode)
          MODE_PAUSE: hold = 1'b1;
          MODE_INTO: begin
            if (count_goal != 0) begin
              if (it.retired_instructions - start_count >= count_goal) begin
                count_goal = '0;
                mode = MODE_PAUSE;
                hold = 1'b1;
              end
            end else if (!it.cpu_waiting && start_clock != it.clock_ticks) begin
              mode = MODE_PAUSE;
              hold = 1'b1;
            end
          end
          MODE_OVER: begin
            if (exited || (!it.cpu_waiting && same && at_goal)) begin
              mode = MODE_PAUSE;
              hold = 1'b1;
            end
          end
          MODE_OUT_RUN: begin
            if (exited) begin
              mode = MODE_PAUSE;
              hold = 1'b1;
            end else if (same) begin
              void'(aim_out(it));
            end
          end
          MODE_OUT_OVER: begin
            if (exited) begin
              mode = MODE_PAUSE;
              hold = 1'b1;
            end else if (same && at_goal) begin
              mode = MODE_OUT_RUN;
              hold = 1'b1;
            end
          end
          MODE_OUT_RETURN: begin
            if (exited || (same && at_goal)) begin
              mode = MODE_PAUSE;
              hold = 1'b1;
            end
          end
          default: ;
        endcase
      end
      OP_CONTINUE: begin
        mode        = MODE_RUN;
        start_clock = it.clock_ticks;
        start_count = it.retired_instructions;
        start_irq   = 1'b1;
      end
      OP_PAUSE: mode = MODE_PAUSE;
      OP_INTO: arm_into(it, it.step_count);
      OP_OVER: begin
        if (it.opcode == OPC_JSR || it.opcode == OPC_WAI) begin
          mode        = MODE_OVER;
          start_clock = it.clock_ticks;
          start_count = it.retired_instructions;
          start_irq   = it.irq_disable;
          goal_pc     = it.pc + ((it.opcode == OPC_JSR) ? JSR_LENGTH : WAI_LENGTH);
          goal_bank   = window_bank(it.pc, it);
        end else begin
          arm_into(it, 32'd0);
        end
      end
      OP_OUT: begin
        start_clock = it.clock_ticks;
        start_irq   = it.irq_disable;
        if (!aim_out(it)) mode = MODE_OUT_RUN;
      end
      default: ;
    endcase
    if (it.operation != OP_CHECK) hold = (mode == MODE_PAUSE);
    r.paused          = hold;
    r.next_mode       = mode;
    r.target_address  = goal_pc;
    r.target_bank_out = goal_bank;
    due_decisions.push_back(r);
  endfunction

  function void compare(string field, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %h, got %h", field, want, got);
    end
  endfunction

  function void check_decision(logic [OutDataWidth-1:0] d);
    result_t want;
    if (due_decisions.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", d);
      return;
    end
    want = due_decisions.pop_front();
    compare("paused", 16'(want.paused), 16'(d[0]));
    compare("next_mode", 16'(want.next_mode), 16'(d[3:1]));
    compare("target_address", want.target_address, d[19:4]);
    compare("target_bank_out", 16'(want.target_bank_out), 16'(d[27:20]));
  endfunction
endclass

module cpu_debug_step_controller_tb;

  localparam int RandomItems = 650;
  localparam int CycleLimit  = 400000;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [InDataWidth-1:0]  s_axis_tdata = '0;
  logic [2:0]              s_axis_tuser = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OutDataWidth-1:0] m_axis_tdata;

  step_scoreboard sb = new();

  int unsigned cycle_count = 0;
  int unsigned stall_left  = 0;
  logic        calm        = 1'b0;

  logic [63:0] run_clock = 64'h0000_0001_ffff_ff00;
  logic [31:0] run_count = 32'hffff_ff80;
  logic [15:0] run_pc    = 16'h0800;
  logic        irq_now   = 1'b1;

  cpu_debug_step_controller dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_opcode();
    case ($urandom_range(0, 9))
      0, 1: return OPC_JSR;
      2: return OPC_RTS;
      3: return OPC_RTI;
      4: return OPC_WAI;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic item_t quiet(logic [2:0] op);
    item_t it;
    it = '0;
    it.operation            = op;
    it.pc                   = 16'h1000;
    it.ram_bank             = 8'h11;
    it.rom_bank             = 8'h22;
    it.opcode               = 8'hea;
    it.irq_disable          = 1'b1;
    it.clock_ticks          = run_clock;
    it.retired_instructions = run_count;
    return it;
  endfunction

  function automatic item_t next_random_item();
    item_t       it;
    int unsigned r;
    r = $urandom_range(0, 99);
    run_clock = run_clock + 64'($urandom_range(0, 8));
    run_count = run_count + 32'($urandom_range(0, 2));
    if ($urandom_range(0, 12) == 0) irq_now = ~irq_now;
    it.operation            = OP_CHECK;
    it.ram_bank    = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
    it.rom_bank    = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
    it.opcode               = pick_opcode();
    it.irq_disable          = irq_now;
    it.cpu_waiting          = ($urandom_range(0, 9) == 0);
    it.stack_word_one = $urandom_range(0, 1) ? 16'($urandom) : run_pc + 16'($urandom_range(0, 8));
    it.stack_word_two = $urandom_range(0, 1) ? 16'($urandom) : run_pc + 16'($urandom_range(0, 8));
    it.clock_ticks          = run_clock;
    it.retired_instructions = run_count;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: it.step_count = 32'd0;
      5, 6, 7, 8: it.step_count = 32'($urandom_range(1, 6));
      default: it.step_count = $urandom;
    endcase
    run_pc = ($urandom_range(0, 7) == 0) ? 16'($urandom) : run_pc + 16'($urandom_range(1, 3));
    it.pc = run_pc;
    if (r < 4) begin
      it.operation            = 3'($urandom);
      it.pc                   = 16'($urandom);
      it.irq_disable          = 1'($urandom);
      it.cpu_waiting          = 1'($urandom);
      it.clock_ticks          = {$urandom, $urandom};
      it.retired_instructions = $urandom;
    end else if (r < 18) begin
      case ($urandom_range(0, 9))
        0: it.operation = OP_CONTINUE;
        1: it.operation = OP_PAUSE;
        2, 3: it.operation = OP_INTO;
        4, 5: it.operation = OP_OVER;
        6, 7, 8: it.operation = OP_OUT;
        default: it.operation = 3'($urandom_range(6, 7));
      endcase
    end else if ($urandom_range(0, 99) < 35) begin
      it.pc = sb.goal_pc;
      if (sb.goal_pc >= ROM_WINDOW_BASE) it.rom_bank = sb.goal_bank;
      else if (sb.goal_pc >= RAM_WINDOW_BASE) it.ram_bank = sb.goal_bank;
    end
    return it;
  endfunction

  task automatic send_item(input item_t it);
    int unsigned gap;
    gap = idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.operation;
    s_axis_tdata  <= {6'd0, it.step_count, it.retired_instructions, it.clock_ticks,
                      it.stack_word_two, it.stack_word_one, it.cpu_waiting, it.irq_disable,
                      it.opcode, it.rom_bank, it.ram_bank, it.pc};
    do @(negedge clk); while (!s_axis_tready);
    @(posedge clk);
    sb.note_item(it);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 256 == 0) calm <= ($urandom_range(0, 2) == 0);
    if (cycle_count > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      stall_left    <= idle_len();
      m_axis_tready <= 1'b1;
    end
  end

  always @(negedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_decision(m_axis_tdata);
  end

  initial begin
    item_t it;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_item(quiet(OP_CHECK));
    send_item(quiet(OP_PAUSE));
    send_item(quiet(OP_CHECK));

    it = quiet(OP_INTO); it.clock_ticks = 64'd100; send_item(it);
    it = quiet(OP_CHECK); it.clock_ticks = 64'd100; send_item(it);
    it.clock_ticks = 64'd101; it.cpu_waiting = 1'b1; send_item(it);
    it.cpu_waiting = 1'b0; send_item(it);

    it = quiet(OP_INTO); it.retired_instructions = 32'hffff_fffe; it.step_count = 32'd3;
    send_item(it);
    it.operation = OP_CHECK; it.retired_instructions = 32'd0; send_item(it);
    it.retired_instructions = 32'd1; send_item(it);

    it = quiet(OP_OVER); it.pc = 16'hfffe; it.opcode = OPC_JSR; it.irq_disable = 1'b0;
    send_item(it);
    it = quiet(OP_CHECK); it.pc = 16'h0001; it.irq_disable = 1'b0; it.cpu_waiting = 1'b1;
    send_item(it);
    it.cpu_waiting = 1'b0; send_item(it);

    it = quiet(OP_OVER); it.pc = 16'hb000; it.ram_bank = 8'hff; it.opcode = OPC_WAI;
    send_item(it);
    it = quiet(OP_CHECK); it.irq_disable = 1'b0; send_item(it);
    it = quiet(OP_OVER); send_item(it);

    it = quiet(OP_OUT); it.opcode = OPC_RTS; it.stack_word_one = 16'hffff; send_item(it);
    it = quiet(OP_CHECK); it.pc = 16'h0000; send_item(it);

    it = quiet(OP_OUT); it.opcode = OPC_RTI; it.stack_word_two = 16'hc123; it.rom_bank = 8'h07;
    send_item(it);
    it = quiet(OP_CHECK); it.pc = 16'hc123; it.rom_bank = 8'h08; send_item(it);
    it.rom_bank = 8'h07; send_item(it);

    send_item(quiet(OP_OUT));
    it = quiet(OP_CHECK); it.pc = 16'ha000; it.ram_bank = 8'h05; it.opcode = OPC_JSR;
    send_item(it);
    it.pc = 16'ha003; it.opcode = 8'hea; send_item(it);
    it.opcode = OPC_RTS; it.stack_word_one = 16'h1234; send_item(it);
    it = quiet(OP_CHECK); it.irq_disable = 1'b0; send_item(it);

    send_item(quiet(3'd6));
    send_item(quiet(3'd7));
    it = '1; it.operation = OP_CONTINUE; send_item(it);
    it = '0; send_item(it);

    repeat (RandomItems) send_item(next_random_item());
    s_axis_tvalid <= 1'b0;

    while (sb.due_decisions.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
